### sv/ttl_aging_address_table_macros.svh
// Assertion macros used by the checker file of the TTL aging address table.
`ifndef TTL_AGING_ADDRESS_TABLE_MACROS_SVH
`define TTL_AGING_ADDRESS_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define TTLAT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clock and disabled during reset.
`define TTLAT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

### sv/ttlat_pkg.sv
// Types and constants shared by the TTL aging address table modules.
package ttlat_pkg;

   localparam int ADDR_W       = 32;
   localparam int TTL_W        = 8;
   localparam int SLOT_FIELD_W = 4;
   localparam int REQ_DATA_W   = 32;
   localparam int RSP_DATA_W   = 40;
   localparam int RSP_USER_W   = 2;
   localparam int ENTRY_W      = ADDR_W + TTL_W;
   localparam logic [TTL_W-1:0] MAX_TTL_RESET = 8'd255;

   typedef enum logic [1:0] {
      ACT_REFRESH = 2'd0,
      ACT_RELEASE = 2'd1,
      ACT_ASSIGN  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SCAN   = 2'd1,
      ST_ASSIGN = 2'd2
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic hit_done;
      logic assign_slot;
   } ctrl_cmd_type;

   typedef struct packed {
      logic slot_valid;
      logic hit;
      logic expire;
      logic last_slot;
      logic out_free;
   } dp_status_type;

endpackage

### sv/ttlat_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ttlat_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/ttlat_ctrl.sv
// Controller state machine that sequences the slot scan and result emission.
module ttlat_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  ttlat_pkg::dp_status_type st,
   output ttlat_pkg::ctrl_cmd_type  cmd
);

   ttlat_pkg::state_type state_ff;
   ttlat_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ttlat_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ttlat_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ttlat_pkg::ST_SCAN;
            end
         end
         ttlat_pkg::ST_SCAN: begin
            if (st.slot_valid && (st.hit || st.expire) && !st.out_free) begin
               state_in = ttlat_pkg::ST_SCAN;
            end else if (st.slot_valid && st.hit) begin
               cmd.hit_done = 1'b1;
               state_in     = ttlat_pkg::ST_IDLE;
            end else begin
               cmd.step = 1'b1;
               if (st.last_slot) begin
                  state_in = ttlat_pkg::ST_ASSIGN;
               end
            end
         end
         ttlat_pkg::ST_ASSIGN: begin
            if (st.out_free) begin
               cmd.assign_slot = 1'b1;
               state_in        = ttlat_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ttlat_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### sv/ttlat_dpath.sv
// Datapath with slot storage, scan registers, TTL arithmetic and the result register.
module ttlat_dpath #(
   parameter int SLOT_COUNT = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [ttlat_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                               csr_valid,
   input  logic [ttlat_pkg::TTL_W-1:0]        csr_data,
   input  logic                               rsp_tready,
   output logic                               rsp_tvalid,
   output logic [ttlat_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [ttlat_pkg::RSP_USER_W-1:0]   rsp_tuser,
   output logic                               rsp_tlast,
   input  ttlat_pkg::ctrl_cmd_type            cmd,
   output ttlat_pkg::dp_status_type           st
);

   localparam int IDX_W = SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

   logic [ttlat_pkg::ADDR_W-1:0]       req_addr_ff, req_addr_in;
   logic [IDX_W-1:0]                   idx_ff, idx_in;
   logic                               free_found_ff, free_found_in;
   logic [IDX_W-1:0]                   free_idx_ff, free_idx_in;
   logic [ttlat_pkg::TTL_W:0]          min_ttl_ff, min_ttl_in;
   logic [IDX_W-1:0]                   min_idx_ff, min_idx_in;
   logic [SLOT_COUNT-1:0]              valid_ff, valid_in;
   logic [ttlat_pkg::TTL_W-1:0]        max_ttl_ff, max_ttl_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   ttlat_pkg::action_type              rsp_action_ff, rsp_action_in;
   logic [ttlat_pkg::SLOT_FIELD_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [ttlat_pkg::ADDR_W-1:0]       rsp_addr_ff, rsp_addr_in;
   logic                               rsp_last_ff, rsp_last_in;

   logic [ttlat_pkg::ENTRY_W-1:0] rd_data;
   logic [ttlat_pkg::ENTRY_W-1:0] wr_data;
   logic [IDX_W-1:0]              rd_addr;
   logic [IDX_W-1:0]              wr_addr;
   logic                          wr_en;
   logic [ttlat_pkg::ADDR_W-1:0]  ram_ip;
   logic [ttlat_pkg::TTL_W-1:0]   ram_ttl;
   logic [ttlat_pkg::TTL_W-1:0]   ttl_dec;
   logic [ttlat_pkg::TTL_W-1:0]   ttl_load;
   logic [IDX_W-1:0]              pick;
   logic                          slot_v;
   logic                          hit;
   logic                          expire;
   logic                          last_slot;
   logic                          out_free;

   ttlat_ram #(
      .WIDTH(ttlat_pkg::ENTRY_W),
      .DEPTH(SLOT_COUNT)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign ram_ip    = rd_data[ttlat_pkg::ENTRY_W-1:ttlat_pkg::TTL_W];
   assign ram_ttl   = rd_data[ttlat_pkg::TTL_W-1:0];
   assign slot_v    = valid_ff[idx_ff];
   assign hit       = (ram_ip == req_addr_ff);
   assign ttl_dec   = (ram_ttl == '0) ? '0 : ram_ttl - 1'b1;
   assign expire    = (ttl_dec == '0);
   assign ttl_load  = (max_ttl_ff == '0) ? ttlat_pkg::TTL_W'(1) : max_ttl_ff;
   assign last_slot = (idx_ff == LAST_IDX);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign pick      = free_found_ff ? free_idx_ff : min_idx_ff;

   assign st.slot_valid = slot_v;
   assign st.hit        = hit;
   assign st.expire     = expire;
   assign st.last_slot  = last_slot;
   assign st.out_free   = out_free;

   always_comb begin
      if (cmd.load) begin
         rd_addr = '0;
      end else if (cmd.step && !last_slot) begin
         rd_addr = IDX_W'(idx_ff + 1'b1);
      end else begin
         rd_addr = idx_ff;
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = {ram_ip, ttl_dec};
      if (cmd.hit_done) begin
         wr_en   = 1'b1;
         wr_data = {req_addr_ff, ttl_load};
      end else if (cmd.step && slot_v && !expire) begin
         wr_en = 1'b1;
      end else if (cmd.assign_slot) begin
         wr_en   = 1'b1;
         wr_addr = pick;
         wr_data = {req_addr_ff, ttl_load};
      end
   end

   always_comb begin
      req_addr_in   = req_addr_ff;
      idx_in        = idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      min_ttl_in    = min_ttl_ff;
      min_idx_in    = min_idx_ff;
      valid_in      = valid_ff;
      max_ttl_in    = csr_valid ? csr_data : max_ttl_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_action_in = rsp_action_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_last_in   = rsp_last_ff;
      if (cmd.load) begin
         req_addr_in   = req_tdata;
         idx_in        = '0;
         free_found_in = 1'b0;
         free_idx_in   = '0;
         min_ttl_in    = {1'b1, {ttlat_pkg::TTL_W{1'b0}}};
         min_idx_in    = '0;
      end
      if (cmd.hit_done) begin
         rsp_valid_in  = 1'b1;
         rsp_action_in = ttlat_pkg::ACT_REFRESH;
         rsp_slot_in   = ttlat_pkg::SLOT_FIELD_W'(idx_ff);
         rsp_addr_in   = req_addr_ff;
         rsp_last_in   = 1'b1;
      end
      if (cmd.step) begin
         if (!last_slot) begin
            idx_in = IDX_W'(idx_ff + 1'b1);
         end
         if (!slot_v) begin
            free_found_in = 1'b1;
            free_idx_in   = idx_ff;
         end else if (expire) begin
            free_found_in    = 1'b1;
            free_idx_in      = idx_ff;
            valid_in[idx_ff] = 1'b0;
            rsp_valid_in     = 1'b1;
            rsp_action_in    = ttlat_pkg::ACT_RELEASE;
            rsp_slot_in      = ttlat_pkg::SLOT_FIELD_W'(idx_ff);
            rsp_addr_in      = ram_ip;
            rsp_last_in      = 1'b0;
         end else if ({1'b0, ttl_dec} < min_ttl_ff) begin
            min_ttl_in = {1'b0, ttl_dec};
            min_idx_in = idx_ff;
         end
      end
      if (cmd.assign_slot) begin
         valid_in[pick] = 1'b1;
         rsp_valid_in   = 1'b1;
         rsp_action_in  = ttlat_pkg::ACT_ASSIGN;
         rsp_slot_in    = ttlat_pkg::SLOT_FIELD_W'(pick);
         rsp_addr_in    = req_addr_ff;
         rsp_last_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         max_ttl_ff   <= ttlat_pkg::MAX_TTL_RESET;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         valid_ff     <= valid_in;
         max_ttl_ff   <= max_ttl_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      req_addr_ff   <= req_addr_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      min_ttl_ff    <= min_ttl_in;
      min_idx_ff    <= min_idx_in;
      rsp_action_ff <= rsp_action_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_addr_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_action_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### sv/ttl_aging_address_table.sv
// Top level of the TTL aging address table: controller, datapath and configuration port.
// One request is handled at a time; slot storage is read one slot per cycle unless a waiting result
// stalls the scan. A miss scans every slot before its final result; a hit in slot k ends the scan there.
// A stalled result halts the scan only when the current slot or the assignment has another result to give.
// Reset clears all slot valid bits and sets max_ttl to 255; no clearing pass is run.
module ttl_aging_address_table #(
   parameter int SLOT_COUNT = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ttlat_pkg::REQ_DATA_W-1:0] req_tdata,  // [31:0] ip_address
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ttlat_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [3:0] slot, [35:4] slot_address
   output logic [ttlat_pkg::RSP_USER_W-1:0] rsp_tuser,  // [1:0] action
   output logic                             rsp_tlast,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ttlat_pkg::TTL_W-1:0]      csr_data
);

   ttlat_pkg::ctrl_cmd_type  cmd;
   ttlat_pkg::dp_status_type st;

   assign csr_ready = 1'b1;

   ttlat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .st        (st),
      .cmd       (cmd)
   );

   ttlat_dpath #(
      .SLOT_COUNT(SLOT_COUNT)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_tready(rsp_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast),
      .cmd       (cmd),
      .st        (st)
   );

endmodule

### sv/ttlat_checker.sv
// Port-level checker for the TTL aging address table and its bind statement.
`include "ttl_aging_address_table_macros.svh"

module ttlat_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [ttlat_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [ttlat_pkg::RSP_USER_W-1:0] rsp_tuser,
   input logic                             rsp_tlast
);

   // Only release results may be followed by more results of the same request.
   `TTLAT_ASSERT_NOW(a_last_by_action, rsp_tvalid, rsp_tlast == (rsp_tuser != 2'(ttlat_pkg::ACT_RELEASE)), "tlast does not match the action")

   // A request transaction starts a scan, so the next cycle cannot take another one.
   `TTLAT_ASSERT_NEXT(a_one_request, req_tvalid && req_tready, !req_tready, "request accepted while a scan is running")

   // A result cannot appear in the cycle right after a request is accepted.
   `TTLAT_ASSERT_NEXT(a_no_early_result, req_tvalid && req_tready && !rsp_tvalid, !rsp_tvalid, "result appeared before any slot was scanned")

   // A stalled result transaction holds its payload.
   `TTLAT_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled result changed")

endmodule

bind ttl_aging_address_table ttlat_checker u_ttlat_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser),
   .rsp_tlast (rsp_tlast)
);

### sim/tb_ttl_aging_address_table.sv
// Self-checking testbench for the TTL aging address table with a scoreboard-based predictor.
`timescale 1ns / 100ps

module tb_ttl_aging_address_table;

   localparam int SLOTS         = 16;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int LONG_HOLD     = 150;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = SLOTS + 8;

   typedef struct {
      ttlat_pkg::action_type        action;
      logic [3:0]                   slot;
      logic [ttlat_pkg::ADDR_W-1:0] address;
      logic                         last;
   } slot_event_type;

   class slot_table_scoreboard;
      logic [ttlat_pkg::TTL_W-1:0]  max_ttl;
      bit                           slot_valid [SLOTS];
      logic [ttlat_pkg::ADDR_W-1:0] slot_ip [SLOTS];
      logic [ttlat_pkg::TTL_W-1:0]  slot_ttl [SLOTS];
      slot_event_type               event_q [$];
      int                           errors;
      int                           n_requests;
      int                           n_refresh;
      int                           n_release;
      int                           n_assign;

      function new();
         max_ttl = ttlat_pkg::MAX_TTL_RESET;
         foreach (slot_valid[i]) slot_valid[i] = 1'b0;
         errors     = 0;
         n_requests = 0;
         n_refresh  = 0;
         n_release  = 0;
         n_assign   = 0;
      endfunction

      function void set_max_ttl(logic [ttlat_pkg::TTL_W-1:0] value);
         max_ttl = value;
      endfunction

      function int pending();
         return event_q.size();
      endfunction

      function void queue_event(ttlat_pkg::action_type act, int idx,
                                logic [ttlat_pkg::ADDR_W-1:0] addr, logic fin);
         slot_event_type e;
         e.action  = act;
         e.slot    = idx[3:0];
         e.address = addr;
         e.last    = fin;
         event_q.push_back(e);
      endfunction

      // Scans the slots in index order, aging, releasing and then refreshing or assigning.
      function void note_request(logic [ttlat_pkg::ADDR_W-1:0] ip);
         int free_idx = -1;
         int min_idx = 0;
         int min_ttl = 256;
         int pick;
         logic [ttlat_pkg::TTL_W-1:0] load;
         load = (max_ttl == '0) ? 8'd1 : max_ttl;
         n_requests++;
         for (int i = 0; i < SLOTS; i++) begin
            if (!slot_valid[i]) begin
               free_idx = i;
               continue;
            end
            if (slot_ip[i] == ip) begin
               slot_ttl[i] = load;
               queue_event(ttlat_pkg::ACT_REFRESH, i, ip, 1'b1);
               n_refresh++;
               return;
            end
            if (slot_ttl[i] != '0) slot_ttl[i] = slot_ttl[i] - 8'd1;
            if (slot_ttl[i] == '0) begin
               slot_valid[i] = 1'b0;
               queue_event(ttlat_pkg::ACT_RELEASE, i, slot_ip[i], 1'b0);
               n_release++;
               free_idx = i;
            end else if (int'(slot_ttl[i]) < min_ttl) begin
               min_ttl = int'(slot_ttl[i]);
               min_idx = i;
            end
         end
         pick = (free_idx >= 0) ? free_idx : min_idx;
         slot_valid[pick] = 1'b1;
         slot_ip[pick]    = ip;
         slot_ttl[pick]   = load;
         queue_event(ttlat_pkg::ACT_ASSIGN, pick, ip, 1'b1);
         n_assign++;
      endfunction

      function void report_field(string field, logic [ttlat_pkg::ADDR_W-1:0] want,
                                 logic [ttlat_pkg::ADDR_W-1:0] got);
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
         errors++;
      endfunction

      function void check_result(ttlat_pkg::action_type act, logic [3:0] slot,
                                 logic [ttlat_pkg::ADDR_W-1:0] addr, logic fin);
         slot_event_type e;
         if (event_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual action %0d slot %0d %s",
                     $time, act, slot, $sformatf("addr 0x%0h last %0b", addr, fin));
            errors++;
            return;
         end
         e = event_q.pop_front();
         if (act !== e.action) report_field("action", 32'(e.action), 32'(act));
         if (slot !== e.slot) report_field("slot", 32'(e.slot), 32'(slot));
         if (addr !== e.address) report_field("slot_address", e.address, addr);
         if (fin !== e.last) report_field("last", 32'(e.last), 32'(fin));
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [ttlat_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [ttlat_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [ttlat_pkg::RSP_USER_W-1:0] rsp_tuser;
   logic                             rsp_tlast;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [ttlat_pkg::TTL_W-1:0]      csr_data;

   bit quiet;
   bit hold_rsp;
   int n_settings;
   int cycle_count;

   slot_table_scoreboard table_sb = new();

   ttl_aging_address_table #(
      .SLOT_COUNT(SLOTS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            table_sb.check_result(ttlat_pkg::action_type'(rsp_tuser), rsp_tdata[3:0],
                                  rsp_tdata[35:4], rsp_tlast);
         end
         if (req_tvalid && req_tready) table_sb.note_request(req_tdata);
         if (csr_valid && csr_ready) table_sb.set_max_ttl(csr_data);
      end
   end

   // Result receiver: random short stalls, plus one long hold-off on request.
   initial begin
      int hold_left;
      int gap_left;
      hold_left = 0;
      gap_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(1, 3) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_ip(input logic [ttlat_pkg::ADDR_W-1:0] ip);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ip;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (table_sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_max_ttl(input logic [ttlat_pkg::TTL_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   task automatic run_random_phase(input logic [ttlat_pkg::TTL_W-1:0] ttl, input int n_items,
                                   input int pool_size, input bit with_hold);
      logic [ttlat_pkg::ADDR_W-1:0] pool [32];
      logic [ttlat_pkg::ADDR_W-1:0] ip;
      write_max_ttl(ttl);
      for (int i = 0; i < pool_size; i++) pool[i] = $urandom;
      for (int k = 0; k < n_items; k++) begin
         if ($urandom_range(0, 99) < 85) ip = pool[$urandom_range(0, pool_size - 1)];
         else ip = $urandom;
         if (with_hold && k == 5) hold_rsp = 1'b1;
         send_ip(ip);
      end
      settle();
   endtask

   initial begin
      logic [ttlat_pkg::ADDR_W-1:0] fill [SLOTS];
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      quiet      = 1'b0;
      hold_rsp   = 1'b0;
      n_settings = 0;
      cycle_count = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_ip(32'h0000_0000);
      send_ip(32'hFFFF_FFFF);
      send_ip(32'h0000_0000);
      for (int i = 0; i < SLOTS - 2; i++) begin
         fill[i] = {16'hA5C3, 16'(i * 16'h1111)};
         send_ip(fill[i]);
      end
      // The table is full now, so this miss replaces the slot with the smallest TTL.
      send_ip(32'h8000_0001);
      settle();

      // Refresh slots 1 and 0 to the same low TTL so the next miss sees a tie.
      write_max_ttl(8'd2);
      send_ip(fill[SLOTS - 4]);
      send_ip(fill[SLOTS - 3]);
      send_ip(32'h7FFF_FFFE);
      send_ip(32'h1234_5678);
      settle();

      write_max_ttl(8'd0);
      send_ip(32'h0F0F_0F0F);
      send_ip(32'hF0F0_F0F0);
      settle();

      run_random_phase(8'd255, 30, 24, 1'b0);
      run_random_phase(8'd3, 30, 10, 1'b1);
      run_random_phase(8'd1, 28, 6, 1'b0);
      run_random_phase(8'd0, 28, 6, 1'b0);
      run_random_phase(8'd12, 30, 20, 1'b0);
      run_random_phase(8'($urandom_range(1, 255)), 30, 16, 1'b0);
      run_random_phase(8'd255, 30, 12, 1'b0);
      quiet = 1'b1;
      run_random_phase(8'd5, 30, 14, 1'b0);

      repeat (TAIL_CYCLES) @(negedge clock);
      $display("Covered %0d requests over %0d TTL settings, with one long result stall.",
               table_sb.n_requests, n_settings);
      $display("Results seen: %0d refreshes, %0d releases, %0d assignments.",
               table_sb.n_refresh, table_sb.n_release, table_sb.n_assign);
      if (table_sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+sv
sv/ttlat_pkg.sv
sv/ttlat_ram.sv
sv/ttlat_ctrl.sv
sv/ttlat_dpath.sv
sv/ttl_aging_address_table.sv
sv/ttlat_checker.sv
sim/tb_ttl_aging_address_table.sv
